### sv/tcp_pkg.sv
// package: types, character codes and constants of the timecode text parser
`timescale 1ns / 1ps
package tcp_pkg;

   // parse phases of the byte scanner
   typedef enum logic [2:0] {
      PH_LEAD       = 3'd0,
      PH_DIGITS     = 3'd1,
      PH_TRAIL      = 3'd2,
      PH_FRAC       = 3'd3,
      PH_FRAC_TRAIL = 3'd4,
      PH_ERROR      = 3'd5
   } phase_type;

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam int unsigned TIME_W = 46;
   localparam int unsigned FRAC_W = 20;
   localparam int unsigned FRAC_KEEP = 6;      // fraction digits that reach microseconds
   localparam int unsigned WEIGHT_W = 17;

   localparam longint unsigned SEC_PER_MIN  = 64'd60;
   localparam longint unsigned USEC_PER_SEC = 64'd1000000;
   localparam longint unsigned TIME_MAX     = (64'd1 << TIME_W) - 64'd1;
   // largest second count whose microsecond value still fits
   localparam longint unsigned SECS_LIMIT   = TIME_MAX / USEC_PER_SEC;
   localparam int unsigned SECS_W = $clog2(SECS_LIMIT + 64'd1);

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic              well_formed;
      logic [TIME_W-1:0] time_micros;
   } rsp_type;

   // end-of-text summary handed from the scanner to the scaling stage
   typedef struct packed {
      logic              ok;
      logic              sat;
      logic [SECS_W-1:0] secs;
      logic [FRAC_W-1:0] frac;
   } scan_sum_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   // microsecond weight of a fraction digit at a given position
   function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [2:0] pos);
      logic [WEIGHT_W-1:0] w;
      unique case (pos)
         3'd0:    w = 17'd100000;
         3'd1:    w = 17'd10000;
         3'd2:    w = 17'd1000;
         3'd3:    w = 17'd100;
         3'd4:    w = 17'd10;
         3'd5:    w = 17'd1;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

endpackage

### sv/tcp_scan.sv
// byte scanner: parse state machine and end-of-text summary
`timescale 1ns / 1ps
module tcp_scan #(
   parameter int MAX_PART_DIGITS     = 4,
   parameter int MAX_FRACTION_DIGITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  tcp_pkg::req_type     word,
   output tcp_pkg::scan_sum_type sum
);
   import tcp_pkg::*;

   localparam longint unsigned PART_MAX  = 64'(10 ** MAX_PART_DIGITS) - 64'd1;
   localparam longint unsigned SOFAR_MAX = PART_MAX * SEC_PER_MIN + PART_MAX;
   localparam longint unsigned SECS_MAX  = SOFAR_MAX * SEC_PER_MIN + PART_MAX;
   localparam int PV_W  = $clog2(PART_MAX + 64'd1);
   localparam int SF_W  = $clog2(SOFAR_MAX + 64'd1);
   localparam int SC_W  = $clog2(SECS_MAX + 64'd1);
   localparam int PC_W  = $clog2(MAX_PART_DIGITS + 1);
   localparam int FC_W  = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int CMP_W = (SC_W > SECS_W) ? SC_W : SECS_W;

   phase_type         phase_ff, phase_in, phase_upd;
   logic [1:0]        colon_ff, colon_in, colon_upd;
   logic [PC_W-1:0]   part_cnt_ff, part_cnt_in, part_cnt_upd;
   logic [PV_W-1:0]   part_ff, part_in, part_upd;
   logic [SF_W-1:0]   sofar_ff, sofar_in, sofar_upd;
   logic [FRAC_W-1:0] frac_ff, frac_in, frac_upd;
   logic [FC_W-1:0]   frac_cnt_ff, frac_cnt_in, frac_cnt_upd;

   logic [3:0]        digit;
   logic [3:0]        frac_cnt_wide;
   logic [SC_W-1:0]   secs;
   logic [CMP_W-1:0]  secs_ext;
   logic              sat;

   assign digit = word.char_code[3:0];
   assign frac_cnt_wide = 4'(frac_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEAD;
         colon_ff    <= '0;
         part_cnt_ff <= '0;
         part_ff     <= '0;
         sofar_ff    <= '0;
         frac_ff     <= '0;
         frac_cnt_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         colon_ff    <= colon_in;
         part_cnt_ff <= part_cnt_in;
         part_ff     <= part_in;
         sofar_ff    <= sofar_in;
         frac_ff     <= frac_in;
         frac_cnt_ff <= frac_cnt_in;
      end
   end

   // one byte of parsing
   always_comb begin
      phase_upd    = phase_ff;
      colon_upd    = colon_ff;
      part_cnt_upd = part_cnt_ff;
      part_upd     = part_ff;
      sofar_upd    = sofar_ff;
      frac_upd     = frac_ff;
      frac_cnt_upd = frac_cnt_ff;
      if (phase_ff != PH_ERROR) begin
         priority if (is_digit(word.char_code)) begin
            unique case (phase_ff)
               PH_LEAD: begin
                  part_cnt_upd = PC_W'(1);
                  part_upd     = PV_W'(digit);
                  phase_upd    = PH_DIGITS;
               end
               PH_DIGITS: begin
                  if (part_cnt_ff >= PC_W'(MAX_PART_DIGITS)) begin
                     phase_upd = PH_ERROR;
                  end else begin
                     part_cnt_upd = part_cnt_ff + PC_W'(1);
                     part_upd = PV_W'({part_ff, 3'b000} + {part_ff, 1'b0} + (PV_W + 3)'(digit));
                  end
               end
               PH_FRAC: begin
                  if (frac_cnt_ff >= FC_W'(MAX_FRACTION_DIGITS)) begin
                     phase_upd = PH_ERROR;
                  end else begin
                     frac_cnt_upd = frac_cnt_ff + FC_W'(1);
                     // digits past microsecond resolution are dropped
                     if (frac_cnt_wide < 4'(FRAC_KEEP)) begin
                        frac_upd = frac_ff + FRAC_W'(digit * frac_weight(frac_cnt_wide[2:0]));
                     end
                  end
               end
               default: phase_upd = PH_ERROR;
            endcase
         end else if (is_space(word.char_code)) begin
            if (phase_ff == PH_DIGITS) begin
               phase_upd = PH_TRAIL;
            end else if (phase_ff == PH_FRAC) begin
               phase_upd = (frac_cnt_ff == '0) ? PH_ERROR : PH_FRAC_TRAIL;
            end
         end else if (word.char_code == CHAR_COLON) begin
            if ((phase_ff == PH_DIGITS || phase_ff == PH_TRAIL) && colon_ff < 2'd2) begin
               colon_upd    = colon_ff + 2'd1;
               sofar_upd    = SF_W'(sofar_ff * SF_W'(SEC_PER_MIN) + SF_W'(part_ff));
               part_upd     = '0;
               part_cnt_upd = '0;
               phase_upd    = PH_LEAD;
            end else begin
               phase_upd = PH_ERROR;
            end
         end else if (word.char_code == CHAR_COMMA || word.char_code == CHAR_DOT) begin
            if (phase_ff == PH_DIGITS || phase_ff == PH_TRAIL) begin
               frac_upd     = '0;
               frac_cnt_upd = '0;
               phase_upd    = PH_FRAC;
            end else begin
               phase_upd = PH_ERROR;
            end
         end else begin
            phase_upd = PH_ERROR;
         end
      end
   end

   // commit, and return to the start state after the last byte
   always_comb begin
      phase_in    = phase_ff;
      colon_in    = colon_ff;
      part_cnt_in = part_cnt_ff;
      part_in     = part_ff;
      sofar_in    = sofar_ff;
      frac_in     = frac_ff;
      frac_cnt_in = frac_cnt_ff;
      if (take) begin
         if (word.last_char) begin
            phase_in    = PH_LEAD;
            colon_in    = '0;
            part_cnt_in = '0;
            part_in     = '0;
            sofar_in    = '0;
            frac_in     = '0;
            frac_cnt_in = '0;
         end else begin
            phase_in    = phase_upd;
            colon_in    = colon_upd;
            part_cnt_in = part_cnt_upd;
            part_in     = part_upd;
            sofar_in    = sofar_upd;
            frac_in     = frac_upd;
            frac_cnt_in = frac_cnt_upd;
         end
      end
   end

   // a colon as last byte is never well formed, so the old base-60 sum serves
   assign secs     = SC_W'(sofar_ff) * SC_W'(SEC_PER_MIN) + SC_W'(part_upd);
   assign secs_ext = CMP_W'(secs);
   assign sat      = secs_ext > CMP_W'(SECS_LIMIT);

   always_comb begin
      sum.ok   = (colon_upd != 2'd0) &&
                 (phase_upd == PH_DIGITS || phase_upd == PH_TRAIL ||
                  phase_upd == PH_FRAC_TRAIL ||
                  (phase_upd == PH_FRAC && frac_cnt_upd != '0));
      sum.sat  = sat;
      sum.secs = sat ? '0 : secs_ext[SECS_W-1:0];
      sum.frac = frac_upd;
   end

   a_restart: assert property (@(posedge clock) disable iff (reset)
      take && word.last_char |=> phase_ff == PH_LEAD && colon_ff == 2'd0)
      else $error("scanner not back at start after last byte");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR && !take |=> phase_ff == PH_ERROR)
      else $error("error phase left without a byte");

   a_frac_trail: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FRAC_TRAIL |-> frac_cnt_ff != '0)
      else $error("trailing fraction space with empty fraction");

endmodule

### sv/timecode_text_parser.sv
// top level: subtitle timecode text parser, one text byte per word
`timescale 1ns / 1ps
// usage
//   req channel: one text byte per word (char_code) with last_char set on the
//   final byte of a timecode text; a word is taken when req_valid and req_ready
//   are both high
//   rsp channel: one word per text, issued for the byte marked last_char:
//   well_formed and the time in whole microseconds (zero if not well formed)
// timing
//   throughput is one byte per cycle while req_ready is high; every byte goes
//   through the parse state machine in the cycle it is taken
//   after the last byte is taken, the result reaches rsp_valid through the
//   summary register, then the seconds-to-microseconds multiply into the
//   output register
// reset
//   synchronous, active high; clears the parser to the start of a text and
//   empties both pipeline registers
// stalls
//   the summary and output registers act as a two-word buffer; req_ready only
//   drops once both hold a result and the receiver holds rsp_ready low
module timecode_text_parser #(
   parameter int MAX_PART_DIGITS     = 4,
   parameter int MAX_FRACTION_DIGITS = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcp_pkg::rsp_type rsp_data
);
   import tcp_pkg::*;

   localparam logic [FRAC_W-1:0] USEC = FRAC_W'(USEC_PER_SEC);
   localparam logic [TIME_W-1:0] TIME_SAT = TIME_W'(TIME_MAX);

   logic         take;
   logic         out_adv;
   scan_sum_type scan_sum;

   // summary stage
   logic         mid_valid_ff, mid_valid_in;
   scan_sum_type mid_ff;

   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [TIME_W:0]   usec_prod;
   logic [TIME_W:0]   usec_sum;

   tcp_scan #(
      .MAX_PART_DIGITS     (MAX_PART_DIGITS),
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .word  (req_data),
      .sum   (scan_sum)
   );

   // output register frees up when empty or being taken
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !mid_valid_ff || out_adv;
   assign take      = req_valid && req_ready;

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (take && req_data.last_char) begin
         mid_valid_in = 1'b1;
      end else if (out_adv) begin
         mid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_data.last_char) begin
         mid_ff <= scan_sum;
      end
   end

   // seconds to microseconds, saturated past the 46-bit range
   assign usec_prod = (TIME_W+1)'(mid_ff.secs) * (TIME_W+1)'(USEC);
   assign usec_sum  = usec_prod + (TIME_W+1)'(mid_ff.frac);

   always_comb begin
      rsp_in.well_formed = mid_ff.ok;
      if (!mid_ff.ok) begin
         rsp_in.time_micros = '0;
      end else if (mid_ff.sat || (usec_sum > (TIME_W+1)'(TIME_SAT))) begin
         rsp_in.time_micros = TIME_SAT;
      end else begin
         rsp_in.time_micros = usec_sum[TIME_W-1:0];
      end
      rsp_valid_in = out_adv ? mid_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && mid_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_to_mid: assert property (@(posedge clock) disable iff (reset)
      take && req_data.last_char |=> mid_valid_ff)
      else $error("last byte did not load the summary stage");

   a_mid_to_out: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && out_adv |=> rsp_valid_ff)
      else $error("summary word lost on its way to the output");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> mid_valid_ff && rsp_valid_ff)
      else $error("input stalled with room in the pipeline");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.well_formed |-> rsp_ff.time_micros == '0)
      else $error("malformed text with nonzero time");

endmodule

### bench/tb_timecode_text_parser.sv
// testbench of timecode_text_parser: scans text bytes and checks each timecode result
`timescale 1ns / 1ps
module tb_timecode_text_parser;
   import tcp_pkg::*;

   // sizes the block is built with
   localparam int PART_DIGITS_MAX = 4;
   localparam int FRAC_DIGITS_MAX = 6;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   timecode_text_parser #(
      .MAX_PART_DIGITS     (PART_DIGITS_MAX),
      .MAX_FRACTION_DIGITS (FRAC_DIGITS_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // text bytes waiting to be sent, and timecode results waiting to come back
   req_type pending_chars[$];
   rsp_type awaited_times[$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned fail_count = 0;
   logic        req_was_taken;

   // scanner state of the predictor, at the widths the block keeps
   phase_type   scan_phase;
   logic [1:0]  colons;
   logic [2:0]  part_digits;
   logic [13:0] part_val;
   logic [19:0] secs_acc;
   logic [19:0] frac_val;
   logic [2:0]  frac_digits;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // back to the start of a text
   task automatic clear_scan();
      scan_phase  = PH_LEAD;
      colons      = '0;
      part_digits = '0;
      part_val    = '0;
      secs_acc    = '0;
      frac_val    = '0;
      frac_digits = '0;
   endtask

   // scan one accepted text byte; on the final byte queue the timecode it closes
   task automatic scan_word(input req_type w);
      logic [7:0]      c;
      logic            ok;
      longint unsigned secs;
      longint unsigned frac;
      longint unsigned micros;
      rsp_type         r;
      c = w.char_code;
      if (scan_phase != PH_ERROR) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            unique case (scan_phase)
               PH_LEAD: begin
                  part_digits = 3'd1;
                  part_val    = 14'(c - CHAR_ZERO);
                  scan_phase  = PH_DIGITS;
               end
               PH_DIGITS: begin
                  if (part_digits >= PART_DIGITS_MAX) scan_phase = PH_ERROR;
                  else begin
                     part_digits = part_digits + 3'd1;
                     part_val    = 14'(part_val * 10 + (c - CHAR_ZERO));
                  end
               end
               PH_FRAC: begin
                  if (frac_digits >= FRAC_DIGITS_MAX) scan_phase = PH_ERROR;
                  else begin
                     frac_digits = frac_digits + 3'd1;
                     frac_val    = 20'(frac_val * 10 + (c - CHAR_ZERO));
                  end
               end
               default: scan_phase = PH_ERROR;
            endcase
         end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) begin
            // blanks end a part; right after a separator they break the fraction
            if (scan_phase == PH_DIGITS) scan_phase = PH_TRAIL;
            else if (scan_phase == PH_FRAC)
               scan_phase = (frac_digits == 0) ? PH_ERROR : PH_FRAC_TRAIL;
         end else if (c == CHAR_COLON) begin
            if (scan_phase == PH_DIGITS || scan_phase == PH_TRAIL) begin
               if (colons >= 2) scan_phase = PH_ERROR;
               else begin
                  colons      = colons + 2'd1;
                  secs_acc    = 20'(secs_acc * SEC_PER_MIN + part_val);
                  part_val    = '0;
                  part_digits = '0;
                  scan_phase  = PH_LEAD;
               end
            end else scan_phase = PH_ERROR;
         end else if (c == CHAR_COMMA || c == CHAR_DOT) begin
            if (scan_phase == PH_DIGITS || scan_phase == PH_TRAIL) begin
               frac_val    = '0;
               frac_digits = '0;
               scan_phase  = PH_FRAC;
            end else scan_phase = PH_ERROR;
         end else scan_phase = PH_ERROR;
      end
      if (w.last_char) begin
         ok = (colons >= 1) &&
              (scan_phase == PH_DIGITS || scan_phase == PH_TRAIL ||
               scan_phase == PH_FRAC_TRAIL || (scan_phase == PH_FRAC && frac_digits > 0));
         micros = 0;
         if (ok) begin
            secs = longint'(secs_acc) * SEC_PER_MIN + part_val;
            // the fraction counts in units of its own last digit
            frac = frac_val;
            if (frac_digits <= FRAC_KEEP) repeat (FRAC_KEEP - frac_digits) frac = frac * 10;
            else repeat (frac_digits - FRAC_KEEP) frac = frac / 10;
            if (secs > TIME_MAX / USEC_PER_SEC) micros = TIME_MAX;
            else begin
               micros = secs * USEC_PER_SEC + frac;
               if (micros > TIME_MAX) micros = TIME_MAX;
            end
         end
         r.well_formed = ok;
         r.time_micros = micros[TIME_W-1:0];
         awaited_times.insert(awaited_times.size(), r);
         clear_scan();
      end
   endtask

   // one whole text, final byte flagged
   task automatic push_text(input byte unsigned txt[$]);
      req_type w;
      for (int i = 0; i < txt.size(); i++) begin
         w.char_code = txt[i];
         w.last_char = (i == txt.size() - 1);
         pending_chars.insert(pending_chars.size(), w);
      end
   endtask

   task automatic push_string(input string s);
      byte unsigned txt[$];
      for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
      push_text(txt);
   endtask

   function automatic byte unsigned blank_char();
      case ($urandom_range(3))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // any byte at all half the time, otherwise something the scanner reacts to
   function automatic byte unsigned noise_char();
      case ($urandom_range(7))
         0, 1, 2, 3: return byte'($urandom_range(255));
         4:          return CHAR_COLON;
         5:          return ($urandom_range(1) == 1) ? CHAR_COMMA : CHAR_DOT;
         6:          return blank_char();
         default:    return byte'(CHAR_ZERO + $urandom_range(9));
      endcase
   endfunction

   task automatic add_blanks(ref byte unsigned txt[$]);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) txt.insert(txt.size(), blank_char());
   endtask

   // mostly well-formed timecodes with random content; some with wrong part or
   // digit counts, some with one byte spoiled, some plain noise
   task automatic add_random_text();
      byte unsigned txt[$];
      int           kind;
      int           parts;
      int           ndig;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 8)) txt.insert(txt.size(), noise_char());
      end else begin
         parts = ($urandom_range(99) < 90) ? $urandom_range(2, 3)
                                            : (($urandom_range(1) == 1) ? 1 : 4);
         for (int p = 0; p < parts; p++) begin
            if (p > 0) txt.insert(txt.size(), CHAR_COLON);
            add_blanks(txt);
            ndig = ($urandom_range(99) < 92) ? $urandom_range(1, PART_DIGITS_MAX)
                                              : (($urandom_range(1) == 1) ? 0
                                                                          : PART_DIGITS_MAX + 1);
            repeat (ndig) txt.insert(txt.size(), ($urandom_range(4) == 0) ? CHAR_NINE
                                                  : byte'(CHAR_ZERO + $urandom_range(9)));
            add_blanks(txt);
         end
         if ($urandom_range(1) == 1) begin
            txt.insert(txt.size(), ($urandom_range(1) == 1) ? CHAR_COMMA : CHAR_DOT);
            if ($urandom_range(15) == 0) txt.insert(txt.size(), blank_char());
            ndig = ($urandom_range(99) < 92) ? $urandom_range(1, FRAC_DIGITS_MAX)
                                              : (($urandom_range(1) == 1) ? 0
                                                                          : FRAC_DIGITS_MAX + 1);
            repeat (ndig) txt.insert(txt.size(), byte'(CHAR_ZERO + $urandom_range(9)));
            add_blanks(txt);
         end
         if (kind < 25 && txt.size() != 0) txt[$urandom_range(txt.size() - 1)] = noise_char();
      end
      push_text(txt);
   endtask

   // sender: offers the next word at the falling edge once the last one is gone
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_was_taken) begin
         if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_chars.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: ready is redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_was_taken <= 1'b0;
      end else begin
         req_was_taken <= req_valid && req_ready;
         if (req_valid && req_ready) scan_word(req_data);
         if (rsp_valid && rsp_ready) begin
            if (awaited_times.size() == 0) begin
               fail_count++;
               $display("%0t: result with none outstanding: well_formed %0b time_micros %0d",
                        $realtime, rsp_data.well_formed, rsp_data.time_micros);
            end else begin
               if (rsp_data.well_formed !== awaited_times[0].well_formed) begin
                  fail_count++;
                  $display("%0t: well_formed expected %0b, got %0b", $realtime,
                           awaited_times[0].well_formed, rsp_data.well_formed);
               end
               if (rsp_data.time_micros !== awaited_times[0].time_micros) begin
                  fail_count++;
                  $display("%0t: time_micros expected %0d, got %0d", $realtime,
                           awaited_times[0].time_micros, rsp_data.time_micros);
               end
               void'(awaited_times.pop_front());
            end
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      #4000000;
      $display("tb_timecode_text_parser NOT OK");
      $finish;
   end

   // digit one, used to open texts that end in a stray odd byte
   function automatic byte unsigned CHAR_ONE_FREE();
      return byte'(CHAR_ZERO + 1);
   endfunction

   initial begin
      byte unsigned odd_codes[5];
      int           base;
      odd_codes     = '{8'h00, 8'h0B, 8'h0C, 8'h80, 8'hFF};
      send_idle_pct = 30;
      recv_idle_pct = 76;
      clear_scan();

      // directed texts: extremes, then each way a text can go wrong
      push_string("0:0");
      push_string("9999:9999:9999,999999");
      push_string("1:2.5");
      push_string(" 1 :\t2\r\n");
      push_string("12:34:56,000001");
      push_string("1:2.5 ");
      push_string(" \t");                 // blanks only
      push_string(":5");                  // empty part
      push_string("1:2,");                // empty fraction
      push_string("5");                   // single part
      push_string("1:2:3:4");             // four parts
      push_string("1 2:3");               // blank inside a part
      push_string("1:2. 5");              // blank between separator and fraction
      push_string("1,5:2");               // separator before the last part
      push_string("1:2.5.6");             // second separator
      push_string("1:2.5 6");             // digit after fraction trailing blank
      push_string("12345:1");             // part too long
      push_string("1:2.1234567");         // fraction too long
      push_string("1:2a");
      foreach (odd_codes[i]) begin
         byte unsigned txt[$];
         txt = '{CHAR_ONE_FREE(), CHAR_COLON, odd_codes[i]};
         push_text(txt);
      end

      // sender idles often, receiver more often
      base = pending_chars.size();
      while (pending_chars.size() - base < 150) add_random_text();
      while (pending_chars.size() != 0) @(posedge clock);

      // the other way round
      send_idle_pct = 76;
      recv_idle_pct = 30;
      while (pending_chars.size() < 150) add_random_text();
      while (pending_chars.size() != 0) @(posedge clock);

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pending_chars.size() < 150) add_random_text();

      // drain, then wait for anything stray to surface
      while (pending_chars.size() != 0 || req_valid || awaited_times.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && awaited_times.size() == 0) begin
         $display("tb_timecode_text_parser OK");
      end else begin
         $display("tb_timecode_text_parser NOT OK");
      end
      $finish;
   end

   // reset held from the start, released at a falling edge
   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

endmodule
